[hdl/assert_macros.svh]
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CDI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define CDI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cdi_pkg.sv]
`timescale 1ns / 1ps
// shared types, widths and commands of the color span interpolator
package cdi_pkg;

  localparam int unsigned LEN_BITS = 16;
  localparam int unsigned LANES    = 4;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned COLOR_W  = CH_W * LANES;
  localparam int unsigned LANE_W   = (LANES > 1) ? $clog2(LANES) : 1;

  // lane state widths
  localparam int unsigned VAL_W  = 10;
  localparam int unsigned ERR_W  = LEN_BITS + 2;
  localparam int unsigned REM_W  = 8;
  localparam int unsigned QUO_W  = 9;

  // |xs * dy| + half stays below 2^(LEN_BITS+9)
  localparam int unsigned PROD_W = LEN_BITS + CH_W;
  localparam int unsigned DIV_W  = LEN_BITS + 9;

  localparam logic signed [VAL_W-1:0] DIR_UP   = 1;
  localparam logic signed [VAL_W-1:0] DIR_DOWN = -1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef struct packed {
    logic                op;
    logic [LEN_BITS-1:0] start_offset;
    logic [LEN_BITS-1:0] length;
    logic [COLOR_W-1:0]  start_color;
    logic [COLOR_W-1:0]  end_color;
  } in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel;
    logic               segment_done;
  } out_t;

  typedef struct packed {
    logic              load;
    logic              mul_start;
    logic              wr_dy;
    logic              n_start;
    logic              wr_n;
    logic              step;
    logic [LANE_W-1:0] lane;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic xs_nz;
  } status_t;

endpackage

[hdl/cdi_divider.sv]
`timescale 1ns / 1ps
// iterative restoring unsigned divider, one quotient bit per cycle
module cdi_divider #(
  parameter int unsigned DIVIDEND_W = cdi_pkg::DIV_W,
  parameter int unsigned DIVISOR_W  = cdi_pkg::LEN_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic [DIVISOR_W-1:0]  remainder_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  dvs_q;

  logic [DIVISOR_W:0] shifted;
  logic [DIVISOR_W:0] diff;
  logic               ge;

  always_comb begin
    shifted = {rem_q, quo_q[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = ~diff[DIVISOR_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DIVIDEND_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

[hdl/cdi_datapath.sv]
`timescale 1ns / 1ps
// lane state, segment set-up arithmetic, step update and result register
module cdi_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cdi_pkg::cmd_t     cmd_i,
  input  cdi_pkg::in_t      req_i,
  output cdi_pkg::status_t  status_o,
  output cdi_pkg::out_t     rsp_o
);

  // lane state
  logic signed [cdi_pkg::VAL_W-1:0] val_q [cdi_pkg::LANES];
  logic signed [cdi_pkg::VAL_W-1:0] val_d [cdi_pkg::LANES];
  logic signed [cdi_pkg::ERR_W-1:0] err_q [cdi_pkg::LANES];
  logic signed [cdi_pkg::ERR_W-1:0] err_d [cdi_pkg::LANES];
  logic        [cdi_pkg::REM_W-1:0] rem_q [cdi_pkg::LANES];
  logic        [cdi_pkg::REM_W-1:0] rem_d [cdi_pkg::LANES];
  logic signed [cdi_pkg::QUO_W-1:0] quo_q [cdi_pkg::LANES];
  logic signed [cdi_pkg::QUO_W-1:0] quo_d [cdi_pkg::LANES];
  logic        [cdi_pkg::LANES-1:0] dir_q;
  logic        [cdi_pkg::LANES-1:0] dir_d;
  logic [cdi_pkg::LEN_BITS-1:0] pos_q, pos_d;
  logic [cdi_pkg::LEN_BITS-1:0] span_q, span_d;

  // segment set-up holding registers
  logic [cdi_pkg::LEN_BITS-1:0] xs_q;
  logic [cdi_pkg::COLOR_W-1:0]  scol_q;
  logic [cdi_pkg::COLOR_W-1:0]  ecol_q;
  logic [cdi_pkg::PROD_W-1:0]   prod_q;
  logic                         dy_neg_q;
  logic                         n_neg_q;
  cdi_pkg::out_t                rsp_q;

  logic [cdi_pkg::LEN_BITS-1:0] len_eff, xs_eff, half;
  logic [cdi_pkg::CH_W-1:0]     s_b, e_b;
  logic signed [cdi_pkg::CH_W:0] dy;
  logic [cdi_pkg::CH_W-1:0]     dy_abs;
  logic                         dy_pos;
  logic [cdi_pkg::DIV_W-1:0]    p_w, half_w, n_abs;
  logic                         n_neg;
  logic [cdi_pkg::DIV_W-1:0]    div_dividend;
  logic [cdi_pkg::DIV_W-1:0]    div_quo;
  logic [cdi_pkg::LEN_BITS-1:0] div_rem;
  logic                         div_done;
  logic                         advance;
  logic [cdi_pkg::COLOR_W-1:0]  pixel;

  // load-time clamps
  always_comb begin
    len_eff = (req_i.length == '0) ? cdi_pkg::LEN_BITS'(1) : req_i.length;
    xs_eff  = (req_i.start_offset > len_eff) ? len_eff : req_i.start_offset;
    half    = span_q >> 1;
  end

  // per-lane delta of the lane being set up
  always_comb begin
    s_b    = scol_q[cmd_i.lane*cdi_pkg::CH_W +: cdi_pkg::CH_W];
    e_b    = ecol_q[cmd_i.lane*cdi_pkg::CH_W +: cdi_pkg::CH_W];
    dy     = $signed({1'b0, e_b}) - $signed({1'b0, s_b});
    dy_abs = dy[cdi_pkg::CH_W] ? cdi_pkg::CH_W'(-dy) : dy[cdi_pkg::CH_W-1:0];
    dy_pos = ~dy[cdi_pkg::CH_W] && (dy != '0);
  end

  // n = xs*dy + half, as sign and magnitude
  always_comb begin
    p_w    = cdi_pkg::DIV_W'(prod_q);
    half_w = cdi_pkg::DIV_W'(half);
    if (!dy_neg_q) begin
      n_abs = p_w + half_w;
      n_neg = 1'b0;
    end else if (p_w > half_w) begin
      n_abs = p_w - half_w;
      n_neg = 1'b1;
    end else begin
      n_abs = half_w - p_w;
      n_neg = 1'b0;
    end
  end

  assign div_dividend = cmd_i.mul_start ? cdi_pkg::DIV_W'(dy_abs) : n_abs;

  cdi_divider #(
    .DIVIDEND_W (cdi_pkg::DIV_W),
    .DIVISOR_W  (cdi_pkg::LEN_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.mul_start | cmd_i.n_start),
    .dividend_i  (div_dividend),
    .divisor_i   (span_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign advance = pos_q < span_q;

  // saturated pixel from the current lane values
  always_comb begin
    for (int i = 0; i < cdi_pkg::LANES; i++) begin
      if (val_q[i][cdi_pkg::VAL_W-1]) begin
        pixel[i*cdi_pkg::CH_W +: cdi_pkg::CH_W] = '0;
      end else if (val_q[i][cdi_pkg::VAL_W-2:cdi_pkg::CH_W] != '0) begin
        pixel[i*cdi_pkg::CH_W +: cdi_pkg::CH_W] = '1;
      end else begin
        pixel[i*cdi_pkg::CH_W +: cdi_pkg::CH_W] = val_q[i][cdi_pkg::CH_W-1:0];
      end
    end
  end

  always_comb begin
    logic signed [cdi_pkg::VAL_W-1:0] sv;
    logic signed [cdi_pkg::ERR_W-1:0] se;
    logic signed [cdi_pkg::QUO_W-1:0] q9;
    logic signed [cdi_pkg::VAL_W-1:0] qv;
    logic signed [cdi_pkg::ERR_W-1:0] rv;
    logic signed [cdi_pkg::ERR_W-1:0] lv;
    val_d  = val_q;
    err_d  = err_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dir_d  = dir_q;
    pos_d  = pos_q;
    span_d = span_q;
    q9 = cdi_pkg::QUO_W'(div_quo);
    qv = cdi_pkg::VAL_W'(div_quo);
    rv = cdi_pkg::ERR_W'(div_rem);
    lv = cdi_pkg::ERR_W'(span_q);
    sv = '0;
    se = '0;
    if (cmd_i.load) begin
      span_d = len_eff;
      pos_d  = xs_eff;
    end
    if (cmd_i.wr_dy) begin
      quo_d[cmd_i.lane] = dy_neg_q ? -q9 : q9;
      rem_d[cdi_pkg::LANE_W'(cmd_i.lane)] = cdi_pkg::REM_W'(div_rem);
      dir_d[cmd_i.lane] = dy_pos;
      val_d[cmd_i.lane] = cdi_pkg::VAL_W'(s_b);
      err_d[cmd_i.lane] = cdi_pkg::ERR_W'(half);
    end
    if (cmd_i.wr_n) begin
      val_d[cmd_i.lane] = cdi_pkg::VAL_W'(s_b) + (n_neg_q ? -qv : qv);
      err_d[cmd_i.lane] = n_neg_q ? lv + rv : lv - rv;
    end
    if (cmd_i.step && advance) begin
      for (int i = 0; i < cdi_pkg::LANES; i++) begin
        sv = val_q[i] + cdi_pkg::VAL_W'(quo_q[i]);
        se = err_q[i] - $signed(cdi_pkg::ERR_W'(rem_q[i]));
        if (se[cdi_pkg::ERR_W-1]) begin
          sv = sv + (dir_q[i] ? cdi_pkg::DIR_UP : cdi_pkg::DIR_DOWN);
          se = se + lv;
        end
        val_d[i] = sv;
        err_d[i] = se;
      end
      pos_d = pos_q + cdi_pkg::LEN_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cdi_pkg::LANES; i++) begin
        val_q[i] <= '0;
        err_q[i] <= '0;
        rem_q[i] <= '0;
        quo_q[i] <= '0;
      end
      dir_q  <= '0;
      pos_q  <= '0;
      span_q <= cdi_pkg::LEN_BITS'(1);
    end else begin
      val_q  <= val_d;
      err_q  <= err_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dir_q  <= dir_d;
      pos_q  <= pos_d;
      span_q <= span_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xs_q   <= xs_eff;
      scol_q <= req_i.start_color;
      ecol_q <= req_i.end_color;
    end
    if (cmd_i.mul_start) begin
      prod_q   <= xs_q * dy_abs;
      dy_neg_q <= dy[cdi_pkg::CH_W];
    end
    if (cmd_i.n_start) begin
      n_neg_q <= n_neg;
    end
    if (cmd_i.step) begin
      rsp_q.pixel        <= pixel;
      rsp_q.segment_done <= (pos_d >= span_q);
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.xs_nz    = (xs_q != '0);
  assign rsp_o             = rsp_q;

endmodule

[hdl/cdi_ctrl.sv]
`timescale 1ns / 1ps
// controller: handshakes, segment set-up sequencing over lanes
module cdi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_op_i,
  input  logic             out_ready_i,
  input  cdi_pkg::status_t status_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output cdi_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_DYWAIT = 3'd2;
  localparam logic [2:0] S_NGO    = 3'd3;
  localparam logic [2:0] S_NWAIT  = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [cdi_pkg::LANE_W-1:0]  lane_q, lane_d;
  logic                        out_valid_q, out_valid_d;
  logic                        in_fire;
  logic                        last_lane;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign last_lane  = (lane_q == cdi_pkg::LANE_W'(cdi_pkg::LANES - 1));

  always_comb begin
    state_d     = state_q;
    lane_d      = lane_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.lane  = lane_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_op_i == cdi_pkg::OP_STEP) begin
            cmd_o.step  = 1'b1;
            out_valid_d = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            lane_d     = '0;
            state_d    = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_DYWAIT;
      end
      S_DYWAIT: begin
        if (status_i.div_done) begin
          cmd_o.wr_dy = 1'b1;
          if (status_i.xs_nz) begin
            state_d = S_NGO;
          end else if (last_lane) begin
            state_d = S_IDLE;
          end else begin
            lane_d  = lane_q + cdi_pkg::LANE_W'(1);
            state_d = S_MUL;
          end
        end
      end
      S_NGO: begin
        cmd_o.n_start = 1'b1;
        state_d       = S_NWAIT;
      end
      S_NWAIT: begin
        if (status_i.div_done) begin
          cmd_o.wr_n = 1'b1;
          if (last_lane) begin
            state_d = S_IDLE;
          end else begin
            lane_d  = lane_q + cdi_pkg::LANE_W'(1);
            state_d = S_MUL;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lane_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lane_q      <= lane_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/color_span_dda_interpolator_unit.sv]
`timescale 1ns / 1ps
// top level of the four-lane color span error-term interpolator
//
// input channel (in_valid_i / in_ready_o / in_req_i): a start request
// (op = 0) loads length, start offset and both packed colors and gives no
// result; a step request (op = 1) gives one result on the output channel
// output channel (out_valid_o / out_ready_i / out_rsp_o): the pixel before
// the advance, each lane clamped to 0..255, and the segment done flag
// step requests: one per cycle while the receiver keeps up; result registered
// in the cycle after accept; start requests: one shared shift-subtract divider
// produces one quotient bit per cycle over 25 bits, once per lane, twice with a
// nonzero start offset; in_ready_o stays low until every lane is set up
// reset: all lanes zero, span length one, position zero, no result pending
// receiver stall: the result register holds; a further request is taken
// only once the pending result leaves
module color_span_dda_interpolator_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cdi_pkg::in_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cdi_pkg::out_t out_rsp_o
);

  // command and status between controller and datapath
  cdi_pkg::cmd_t    cmd;
  cdi_pkg::status_t status;

  cdi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_req_i.op),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // lane registers, set-up multiply and divide, step update
  cdi_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .req_i    (in_req_i),
    .status_o (status),
    .rsp_o    (out_rsp_o)
  );

endmodule

[hdl/cdi_checker.sv]
`timescale 1ns / 1ps
// port-level checker for the interpolator, bound to the top level
`include "assert_macros.svh"

module cdi_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input cdi_pkg::in_t  in_req_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input cdi_pkg::out_t out_rsp_o
);

  logic start_fire;
  logic step_fire;

  assign start_fire = in_valid_i && in_ready_o && (in_req_i.op == cdi_pkg::OP_START);
  assign step_fire  = in_valid_i && in_ready_o && (in_req_i.op == cdi_pkg::OP_STEP);

  `CDI_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `CDI_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_rsp_o), "result moved")
  `CDI_ASSERT_NEXT(a_step_result, step_fire, out_valid_o, "step gave no result")
  `CDI_ASSERT_NEXT(a_start_busy, start_fire, !in_ready_o && !(out_valid_o && !$past(out_valid_o)), "start not busy")
  `CDI_ASSERT_NOW(a_ready_drain, in_ready_o && out_valid_o, out_ready_i, "request over result")

endmodule

bind color_span_dda_interpolator_unit cdi_checker u_checker (.*);

[tb/sv/color_span_dda_interpolator_unit_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench of the color span interpolator: directed plan, random spans, scoreboard
module color_span_dda_interpolator_unit_tb;
  import cdi_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int QUIET_LIMIT  = 5000;  // cycles with no handshake at all
  localparam int RX_PAUSE     = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 20;
  localparam int PRINT_CAP    = 200;
  localparam int CH_MAX       = (1 << CH_W) - 1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_req;
  logic out_valid;
  logic out_ready;
  out_t out_rsp;

  color_span_dda_interpolator_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  // predicted span state, one entry per color lane
  logic signed [VAL_W-1:0] lane_lvl   [LANES];
  logic signed [ERR_W-1:0] lane_acc   [LANES];
  logic [REM_W-1:0]        lane_frac  [LANES];
  logic signed [QUO_W-1:0] lane_whole [LANES];
  logic                    lane_rising[LANES];
  logic [LEN_BITS-1:0]     span_pos;
  logic [LEN_BITS-1:0]     span_len;

  out_t pixel_due[$];
  int   fail_count = 0;
  int   quiet_cycles = 0;
  int   idle_pct = 35;
  bit   rx_pause_req = 1'b0;

  typedef struct {
    in_t  req;
    bit   fixed;
    out_t rsp;
  } plan_row_t;

  plan_row_t plan[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_span();
    int i;
    for (i = 0; i < LANES; i++) begin
      lane_lvl[i]    = '0;
      lane_acc[i]    = '0;
      lane_frac[i]   = '0;
      lane_whole[i]  = '0;
      lane_rising[i] = 1'b0;
    end
    span_pos = '0;
    span_len = LEN_BITS'(1);
  endfunction

  // start request: per-lane slope split into whole and fractional steps
  function automatic void load_span(input in_t req);
    int     i, xs, len, half, s, e, dy, r_mod;
    longint n;
    len = int'(req.length);
    if (len == 0) len = 1;      // zero length runs as a single pixel
    xs = int'(req.start_offset);
    if (xs > len) xs = len;     // offset past the end lands on the end
    half = len >> 1;
    span_len = LEN_BITS'(len);
    span_pos = LEN_BITS'(xs);
    for (i = 0; i < LANES; i++) begin
      s = int'(req.start_color[CH_W*i +: CH_W]);
      e = int'(req.end_color[CH_W*i +: CH_W]);
      dy = e - s;
      r_mod = dy % len;
      lane_whole[i]  = QUO_W'(dy / len);
      lane_frac[i]   = REM_W'(r_mod < 0 ? -r_mod : r_mod);
      lane_rising[i] = (s < e);
      lane_lvl[i]    = VAL_W'(s);
      lane_acc[i]    = ERR_W'(half);
      if (xs > 0) begin
        // mid-span entry, rounded to nearest
        n = longint'(xs) * longint'(dy) + longint'(half);
        lane_lvl[i] = VAL_W'(s + int'(n / longint'(len)));
        lane_acc[i] = ERR_W'(len - int'(n % longint'(len)));
      end
    end
  endfunction

  // step request: emit clamped lanes, then advance unless the span is done
  function automatic void step_span(output out_t rsp);
    int i, v, a;
    rsp = '0;
    for (i = 0; i < LANES; i++) begin
      v = int'(lane_lvl[i]);
      if (v < 0) v = 0;
      if (v > CH_MAX) v = CH_MAX;
      rsp.pixel[CH_W*i +: CH_W] = CH_W'(v);
    end
    if (span_pos < span_len) begin
      for (i = 0; i < LANES; i++) begin
        v = int'(lane_lvl[i]) + int'(lane_whole[i]);
        a = int'(lane_acc[i]) - int'(lane_frac[i]);
        if (a < 0) begin
          v = v + int'(lane_rising[i] ? DIR_UP : DIR_DOWN);
          a = a + int'(span_len);
        end
        lane_lvl[i] = VAL_W'(v);
        lane_acc[i] = ERR_W'(a);
      end
      span_pos = span_pos + 1'b1;
    end
    rsp.segment_done = (span_pos >= span_len);
  endfunction

  function automatic void apply_request(input in_t req, output out_t rsp, output bit has_rsp);
    has_rsp = (req.op == OP_STEP);
    rsp = '0;
    if (has_rsp) step_span(rsp);
    else load_span(req);
  endfunction

  function automatic in_t step_req();
    in_t req;
    // fields other than op are ignored by a step, so fill them with noise
    req.op           = OP_STEP;
    req.start_offset = LEN_BITS'($urandom);
    req.length       = LEN_BITS'($urandom);
    req.start_color  = $urandom;
    req.end_color    = $urandom;
    return req;
  endfunction

  function automatic in_t start_req(input int off, input int len,
                                    input logic [COLOR_W-1:0] s,
                                    input logic [COLOR_W-1:0] e);
    in_t req;
    req.op           = OP_START;
    req.start_offset = LEN_BITS'(off);
    req.length       = LEN_BITS'(len);
    req.start_color  = s;
    req.end_color    = e;
    return req;
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    logic [COLOR_W-1:0] c;
    int i, p;
    c = $urandom;
    for (i = 0; i < LANES; i++) begin
      p = $urandom_range(99);
      if (p < 20) c[CH_W*i +: CH_W] = '0;
      else if (p < 40) c[CH_W*i +: CH_W] = '1;
    end
    return c;
  endfunction

  function automatic void plan_start(input int off, input int len,
                                     input logic [COLOR_W-1:0] s,
                                     input logic [COLOR_W-1:0] e);
    plan.push_back('{req: start_req(off, len, s, e), fixed: 1'b0, rsp: '0});
  endfunction

  function automatic void plan_step();
    plan.push_back('{req: step_req(), fixed: 1'b0, rsp: '0});
  endfunction

  function automatic void plan_step_at(input logic [COLOR_W-1:0] pix, input logic done);
    plan.push_back('{req: step_req(), fixed: 1'b1, rsp: '{pixel: pix, segment_done: done}});
  endfunction

  task automatic report_mismatch(input string what, input logic [COLOR_W-1:0] want,
                                 input logic [COLOR_W-1:0] got);
    if (fail_count < PRINT_CAP)
      $display("%0t ns: mismatch on %s, expected %h, got %h", $time, what, want, got);
    fail_count++;
  endtask

  // present one request, hold it until accepted, then predict its result
  task automatic offer(input in_t req, input bit fixed = 1'b0, input out_t fixed_rsp = '0);
    out_t rsp;
    bit   has_rsp;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (!in_ready);
    apply_request(req, rsp, has_rsp);
    if (has_rsp) pixel_due.push_back(fixed ? fixed_rsp : rsp);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int hold;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_pause_req) begin
        rx_pause_req = 1'b0;
        for (hold = 0; hold < RX_PAUSE; hold++) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // scoreboard: each accepted result against the oldest prediction
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixel_due.size() == 0) begin
        report_mismatch("result with no request pending", '0, out_rsp.pixel);
      end else begin
        want = pixel_due.pop_front();
        if (out_rsp.pixel !== want.pixel)
          report_mismatch("pixel", want.pixel, out_rsp.pixel);
        if (out_rsp.segment_done !== want.segment_done)
          report_mismatch("segment_done", COLOR_W'(want.segment_done),
                          COLOR_W'(out_rsp.segment_done));
      end
    end
  end

  // watchdog: too long with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int sent, len, off, eff_len, eff_off, n_steps, p, j;
    bit pressed, press_now;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_req   <= '0;
    clear_span();

    // directed plan
    plan.push_back('{req: '1, fixed: 1'b1,                // all ones is a step request
                     rsp: '{pixel: '0, segment_done: 1'b1}});
    plan_step_at('0, 1'b1);                               // still nothing loaded
    plan_start(0, 0, 32'hff00ff00, 32'h00ff00ff);         // zero length runs as one
    plan_step_at(32'hff00ff00, 1'b1);
    plan_step_at(32'h00ff00ff, 1'b1);                     // held after done
    plan_start(65535, 10, 32'h00000000, 32'hffffffff);    // offset past end
    plan_step_at(32'hffffffff, 1'b1);
    plan_start(1, 1, 32'h12345678, 32'h87654321);         // enters at the end
    plan_step_at(32'h87654321, 1'b1);
    plan_start(0, 65535, 32'h00000000, 32'hffffffff);     // longest span, rising
    plan_step_at('0, 1'b0);
    plan_step();
    plan_start(65534, 65535, 32'hffffffff, 32'h00000000); // falling, near end
    plan_step();
    plan_step();
    plan_step();
    plan_start(0, 3, 32'h0a80ff00, 32'hf080000f);         // mixed directions
    repeat (4) plan_step();
    plan_start(2, 5, 32'h5a5a5a5a, 32'h5a5a5a5a);         // flat, mid-span entry
    repeat (3) plan_step();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) offer(plan[k].req, plan[k].fixed, plan[k].rsp);

    // random spans: mostly a start followed by a run of steps
    sent    = 0;
    pressed = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      idle_pct = (sent >= 700 && sent < 1000) ? 0 : 35;
      p = $urandom_range(99);
      if (p < 4) begin
        offer(step_req());                                // stray step
        sent++;
      end else begin
        p = $urandom_range(99);
        if (p < 50) len = $urandom_range(1, 12);
        else if (p < 75) len = $urandom_range(13, 200);
        else if (p < 90) len = $urandom_range(0, 65535);
        else if (p < 95) len = 0;
        else len = 65535;
        eff_len = (len == 0) ? 1 : len;
        p = $urandom_range(99);
        if (p < 55) off = 0;
        else if (p < 70) off = $urandom_range(0, eff_len);
        else if (p < 85) off = eff_len - $urandom_range(0, (eff_len < 8) ? eff_len : 8);
        else off = $urandom_range(0, 65535);
        eff_off = (off > eff_len) ? eff_len : off;
        offer(start_req(off, len, pick_color(), pick_color()));
        sent++;
        if (eff_len - eff_off <= 30) n_steps = $urandom_range(0, eff_len - eff_off + 2);
        else n_steps = $urandom_range(1, 24);
        press_now = !pressed && sent >= 400;
        if (press_now) begin
          pressed = 1'b1;
          n_steps = 30;
        end
        for (j = 0; j < n_steps; j++) begin
          offer(step_req());
          sent++;
          // once one result sits in the block, stall the receiver for a long stretch
          if (press_now && j == 0) rx_pause_req = 1'b1;
        end
      end
    end
    in_valid <= 1'b0;

    while (pixel_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
